// ===== rtl/rect_circle_fill_scanner_core_assert.svh =====
// Assertion macros for the fill scanner RTL.
`ifndef RECT_CIRCLE_FILL_SCANNER_CORE_ASSERT_SVH
`define RECT_CIRCLE_FILL_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and quiet during reset.
`define RCFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet during reset.
`define RCFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rcfs_pkg.sv =====
// Shared types and constants of the rectangle and circle fill scanner.
package rcfs_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ADDR_BITS      = 32;
    localparam int COLOR_BITS     = 32;
    localparam int OFFSET_BITS    = 12;
    localparam int BPP_BITS       = 6;
    localparam int STRIDE_BITS    = 16;
    localparam int PADDR_BITS     = 5;
    localparam int PDATA_BITS     = 32;
    localparam int BYTE_SHIFT     = 3;

    localparam logic [BPP_BITS-1:0] BPP_RESET = 6'd32;

    typedef enum logic [1:0] {
        ACT_RECT   = 2'd0,
        ACT_CIRCLE = 2'd1,
        ACT_STEP   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        REG_FRAME_BASE  = 3'd0,
        REG_X_OFFSET    = 3'd1,
        REG_Y_OFFSET    = 3'd2,
        REG_BPP         = 3'd3,
        REG_LINE_STRIDE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   frame_base;
        logic [OFFSET_BITS-1:0] x_offset;
        logic [OFFSET_BITS-1:0] y_offset;
        logic [BPP_BITS-1:0]    pix_depth;
        logic [STRIDE_BITS-1:0] line_stride;
    } t_cfg;

    typedef struct packed {
        logic circle;
        logic last;
    } t_pos_ctl;

    typedef struct packed {
        logic busy;
        logic at_last;
    } t_scan_status;

endpackage

// ===== rtl/rcfs_scan.sv =====
// Shape state, scan walker: one item per cycle unless stalled; emits scan positions.
module rcfs_scan #(
    parameter int COORD_BITS = rcfs_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_action,
    input  logic signed [COORD_BITS-1:0]    i_pos_x,
    input  logic signed [COORD_BITS-1:0]    i_pos_y,
    input  logic [COORD_BITS-1:0]           i_rect_width,
    input  logic [COORD_BITS-1:0]           i_rect_height,
    input  logic [COORD_BITS-2:0]           i_circle_radius,
    input  logic [rcfs_pkg::COLOR_BITS-1:0] i_fill_color,
    output logic                            o_pos_valid,
    input  logic                            i_pos_ready,
    output logic signed [COORD_BITS+1:0]    o_pos_x,
    output logic signed [COORD_BITS+1:0]    o_pos_y,
    output logic signed [COORD_BITS+1:0]    o_dx,
    output logic signed [COORD_BITS+1:0]    o_dy,
    output logic [COORD_BITS-2:0]           o_radius,
    output logic [rcfs_pkg::COLOR_BITS-1:0] o_color,
    output rcfs_pkg::t_pos_ctl              o_ctl,
    output rcfs_pkg::t_scan_status          o_status
);

    localparam int SB = COORD_BITS + 2;
    localparam logic signed [SB-1:0] ONE_SB = {{(SB-1){1'b0}}, 1'b1};

    // Shape state.
    logic                            r_busy, n_busy;
    logic                            r_circle, n_circle;
    logic signed [SB-1:0]            r_scan_x, n_scan_x;
    logic signed [SB-1:0]            r_scan_y, n_scan_y;
    logic signed [SB-1:0]            r_row_x, n_row_x;
    logic signed [SB-1:0]            r_last_x, n_last_x;
    logic signed [SB-1:0]            r_last_y, n_last_y;
    logic signed [COORD_BITS-1:0]    r_cx, n_cx;
    logic signed [COORD_BITS-1:0]    r_cy, n_cy;
    logic [COORD_BITS-2:0]           r_radius, n_radius;
    logic [rcfs_pkg::COLOR_BITS-1:0] r_color, n_color;

    // Outgoing scan position register.
    logic                            r_pv, n_pv;
    logic signed [SB-1:0]            r_px, n_px;
    logic signed [SB-1:0]            r_py, n_py;
    logic signed [SB-1:0]            r_dx, n_dx;
    logic signed [SB-1:0]            r_dy, n_dy;
    logic [COORD_BITS-2:0]           r_rad, n_rad;
    logic [rcfs_pkg::COLOR_BITS-1:0] r_col, n_col;
    rcfs_pkg::t_pos_ctl              r_ctl, n_ctl;

    logic                 take;
    logic signed [SB-1:0] px_e, py_e, w_e, h_e, r_e, cx_e, cy_e;
    logic                 at_end_x, at_last;

    assign o_in_ready = !r_pv || i_pos_ready;
    assign take       = i_in_valid && o_in_ready;

    assign px_e = {{2{i_pos_x[COORD_BITS-1]}}, i_pos_x};
    assign py_e = {{2{i_pos_y[COORD_BITS-1]}}, i_pos_y};
    assign w_e  = {2'b00, i_rect_width};
    assign h_e  = {2'b00, i_rect_height};
    assign r_e  = {3'b000, i_circle_radius};
    assign cx_e = {{2{r_cx[COORD_BITS-1]}}, r_cx};
    assign cy_e = {{2{r_cy[COORD_BITS-1]}}, r_cy};

    assign at_end_x = (r_scan_x == r_last_x);
    assign at_last  = at_end_x && (r_scan_y == r_last_y);

    always_comb begin
        n_busy   = r_busy;
        n_circle = r_circle;
        n_scan_x = r_scan_x;
        n_scan_y = r_scan_y;
        n_row_x  = r_row_x;
        n_last_x = r_last_x;
        n_last_y = r_last_y;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_radius = r_radius;
        n_color  = r_color;
        n_pv     = r_pv && !i_pos_ready;
        n_px     = r_px;
        n_py     = r_py;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_rad    = r_rad;
        n_col    = r_col;
        n_ctl    = r_ctl;
        if (take) begin
            case (rcfs_pkg::t_action'(i_action))
                rcfs_pkg::ACT_RECT: begin
                    n_circle = 1'b0;
                    n_color  = i_fill_color;
                    if (i_rect_width == '0 || i_rect_height == '0) begin
                        n_busy = 1'b0;
                    end else begin
                        n_busy   = 1'b1;
                        n_row_x  = px_e;
                        n_scan_x = px_e;
                        n_scan_y = py_e;
                        n_last_x = px_e + w_e - ONE_SB;
                        n_last_y = py_e + h_e - ONE_SB;
                    end
                end
                rcfs_pkg::ACT_CIRCLE: begin
                    n_circle = 1'b1;
                    n_color  = i_fill_color;
                    n_busy   = 1'b1;
                    n_cx     = i_pos_x;
                    n_cy     = i_pos_y;
                    n_radius = i_circle_radius;
                    n_row_x  = px_e - r_e;
                    n_scan_x = px_e - r_e;
                    n_scan_y = py_e - r_e;
                    n_last_x = px_e + r_e;
                    n_last_y = py_e + r_e;
                end
                rcfs_pkg::ACT_STEP: begin
                    if (r_busy) begin
                        n_pv         = 1'b1;
                        n_px         = r_scan_x;
                        n_py         = r_scan_y;
                        n_dx         = r_scan_x - cx_e;
                        n_dy         = r_scan_y - cy_e;
                        n_rad        = r_radius;
                        n_col        = r_color;
                        n_ctl.circle = r_circle;
                        n_ctl.last   = at_last;
                        if (at_last) begin
                            n_busy = 1'b0;
                        end else if (at_end_x) begin
                            n_scan_x = r_row_x;
                            n_scan_y = r_scan_y + ONE_SB;
                        end else begin
                            n_scan_x = r_scan_x + ONE_SB;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_circle <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_circle <= n_circle;
            r_pv     <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_x <= n_scan_x;
        r_scan_y <= n_scan_y;
        r_row_x  <= n_row_x;
        r_last_x <= n_last_x;
        r_last_y <= n_last_y;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_radius <= n_radius;
        r_color  <= n_color;
        r_px     <= n_px;
        r_py     <= n_py;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_rad    <= n_rad;
        r_col    <= n_col;
        r_ctl    <= n_ctl;
    end

    assign o_pos_valid      = r_pv;
    assign o_pos_x          = r_px;
    assign o_pos_y          = r_py;
    assign o_dx             = r_dx;
    assign o_dy             = r_dy;
    assign o_radius         = r_rad;
    assign o_color          = r_col;
    assign o_ctl            = r_ctl;
    assign o_status.busy    = r_busy;
    assign o_status.at_last = at_last;

endmodule

// ===== rtl/rcfs_pix.sv =====
// Pixel stage: address products and circle test, then the result register.
module rcfs_pix #(
    parameter int COORD_BITS = rcfs_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rcfs_pkg::t_cfg                  i_cfg,
    input  logic                            i_pos_valid,
    output logic                            o_pos_ready,
    input  logic signed [COORD_BITS+1:0]    i_pos_x,
    input  logic signed [COORD_BITS+1:0]    i_pos_y,
    input  logic signed [COORD_BITS+1:0]    i_dx,
    input  logic signed [COORD_BITS+1:0]    i_dy,
    input  logic [COORD_BITS-2:0]           i_radius,
    input  logic [rcfs_pkg::COLOR_BITS-1:0] i_color,
    input  rcfs_pkg::t_pos_ctl              i_ctl,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_write_enable,
    output logic [rcfs_pkg::ADDR_BITS-1:0]  o_pixel_address,
    output logic [rcfs_pkg::COLOR_BITS-1:0] o_pixel_value,
    output logic                            o_last_position
);

    localparam int SB = COORD_BITS + 2;
    localparam int SQ = 2 * SB;
    localparam int RQ = 2 * (COORD_BITS - 1);
    localparam int AB = rcfs_pkg::ADDR_BITS;

    // Product stage.
    logic                            r_s2_vld;
    logic [AB-1:0]                   r_prod_x, r_prod_y;
    logic [SQ-1:0]                   r_dx2, r_dy2;
    logic [RQ-1:0]                   r_rr;
    logic [rcfs_pkg::COLOR_BITS-1:0] r_s2_col;
    rcfs_pkg::t_pos_ctl              r_s2_ctl;

    // Result register.
    logic                            r_out_vld;
    logic                            r_we;
    logic [AB-1:0]                   r_addr;
    logic [rcfs_pkg::COLOR_BITS-1:0] r_val;
    logic                            r_last;

    logic                 out_free, s2_free, s2_load, out_load;
    logic signed [AB-1:0] ax, ay;
    logic [2:0]           bytes_per_px;
    logic signed [SQ-1:0] dx_w, dy_w;
    logic [SQ:0]          dist2;
    logic                 in_circle;

    assign out_free    = !r_out_vld || i_out_ready;
    assign s2_free     = !r_s2_vld || out_free;
    assign o_pos_ready = s2_free;
    assign s2_load     = i_pos_valid && s2_free;
    assign out_load    = r_s2_vld && out_free;

    // Coordinates wrap at the address width, as the address itself does.
    assign ax = {{(AB-SB){i_pos_x[SB-1]}}, i_pos_x}
              + {{(AB-rcfs_pkg::OFFSET_BITS){1'b0}}, i_cfg.x_offset};
    assign ay = {{(AB-SB){i_pos_y[SB-1]}}, i_pos_y}
              + {{(AB-rcfs_pkg::OFFSET_BITS){1'b0}}, i_cfg.y_offset};
    assign bytes_per_px = i_cfg.pix_depth[rcfs_pkg::BPP_BITS-1:rcfs_pkg::BYTE_SHIFT];

    assign dx_w = {{SB{i_dx[SB-1]}}, i_dx};
    assign dy_w = {{SB{i_dy[SB-1]}}, i_dy};

    assign dist2     = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign in_circle = (dist2 <= {{(SQ+1-RQ){1'b0}}, r_rr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s2_free) begin
                r_s2_vld <= i_pos_valid;
            end
            if (out_free) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_prod_x <= AB'($unsigned(ax) * {{(AB-3){1'b0}}, bytes_per_px});
            r_prod_y <= AB'($unsigned(ay)
                        * {{(AB-rcfs_pkg::STRIDE_BITS){1'b0}}, i_cfg.line_stride});
            r_dx2    <= SQ'($unsigned(dx_w * dx_w));
            r_dy2    <= SQ'($unsigned(dy_w * dy_w));
            r_rr     <= RQ'({{(COORD_BITS-1){1'b0}}, i_radius}
                        * {{(COORD_BITS-1){1'b0}}, i_radius});
            r_s2_col <= i_color;
            r_s2_ctl <= i_ctl;
        end
        if (out_load) begin
            r_we   <= !r_s2_ctl.circle || in_circle;
            r_addr <= i_cfg.frame_base + r_prod_x + r_prod_y;
            r_val  <= r_s2_col;
            r_last <= r_s2_ctl.last;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_write_enable  = r_we;
    assign o_pixel_address = r_addr;
    assign o_pixel_value   = r_val;
    assign o_last_position = r_last;

endmodule

// ===== rtl/rect_circle_fill_scanner_core.sv =====
// Top level of the rectangle and circle fill scanner: registers, input stage and datapath.
// A start item loads a rectangle or a circle and its color and gives no result; each
// step item while a shape is active gives one scan position in row-major order with
// its byte address, color, write enable (circles: inside the radius only) and a last
// mark. Steps while idle, and action code 3, give nothing. The block accepts one item
// every clock while the output is not stalled; a step's result passes through the input
// register, the scan position register, the product register and the result register.
// Configuration sits behind an APB port at byte addresses 0, 4, 8, 12 and 16 and must
// only be written while no item is in flight.
`include "rect_circle_fill_scanner_core_assert.svh"

module rect_circle_fill_scanner_core #(
    parameter int COORD_BITS = rcfs_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rcfs_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [rcfs_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [rcfs_pkg::PDATA_BITS-1:0]  prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_action,
    input  logic signed [COORD_BITS-1:0]     i_pos_x,
    input  logic signed [COORD_BITS-1:0]     i_pos_y,
    input  logic [COORD_BITS-1:0]            i_rect_width,
    input  logic [COORD_BITS-1:0]            i_rect_height,
    input  logic [COORD_BITS-2:0]            i_circle_radius,
    input  logic [rcfs_pkg::COLOR_BITS-1:0]  i_fill_color,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_write_enable,
    output logic [rcfs_pkg::ADDR_BITS-1:0]   o_pixel_address,
    output logic [rcfs_pkg::COLOR_BITS-1:0]  o_pixel_value,
    output logic                             o_last_position
);

    localparam int SB = COORD_BITS + 2;
    localparam int PB = rcfs_pkg::PDATA_BITS;

    rcfs_pkg::t_cfg r_cfg;
    logic           cfg_wr;
    rcfs_pkg::t_reg_idx reg_idx;

    // Input register.
    logic                            r_in_vld;
    logic [1:0]                      r_in_action;
    logic signed [COORD_BITS-1:0]    r_in_pos_x, r_in_pos_y;
    logic [COORD_BITS-1:0]           r_in_width, r_in_height;
    logic [COORD_BITS-2:0]           r_in_radius;
    logic [rcfs_pkg::COLOR_BITS-1:0] r_in_color;

    logic                            scan_ready, scan_take;
    logic                            pos_valid, pos_ready;
    logic signed [SB-1:0]            pos_x, pos_y, pos_dx, pos_dy;
    logic [COORD_BITS-2:0]           pos_radius;
    logic [rcfs_pkg::COLOR_BITS-1:0] pos_color;
    rcfs_pkg::t_pos_ctl              pos_ctl;
    rcfs_pkg::t_scan_status          scan_status;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = rcfs_pkg::t_reg_idx'(paddr[rcfs_pkg::PADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base  <= '0;
            r_cfg.x_offset    <= '0;
            r_cfg.y_offset    <= '0;
            r_cfg.pix_depth   <= rcfs_pkg::BPP_RESET;
            r_cfg.line_stride <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                rcfs_pkg::REG_FRAME_BASE: begin
                    r_cfg.frame_base <= pwdata;
                end
                rcfs_pkg::REG_X_OFFSET: begin
                    r_cfg.x_offset <= pwdata[rcfs_pkg::OFFSET_BITS-1:0];
                end
                rcfs_pkg::REG_Y_OFFSET: begin
                    r_cfg.y_offset <= pwdata[rcfs_pkg::OFFSET_BITS-1:0];
                end
                rcfs_pkg::REG_BPP: begin
                    r_cfg.pix_depth <= pwdata[rcfs_pkg::BPP_BITS-1:0];
                end
                rcfs_pkg::REG_LINE_STRIDE: begin
                    r_cfg.line_stride <= pwdata[rcfs_pkg::STRIDE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rcfs_pkg::REG_FRAME_BASE:  prdata = r_cfg.frame_base;
            rcfs_pkg::REG_X_OFFSET:    prdata = {{(PB-rcfs_pkg::OFFSET_BITS){1'b0}},
                                                 r_cfg.x_offset};
            rcfs_pkg::REG_Y_OFFSET:    prdata = {{(PB-rcfs_pkg::OFFSET_BITS){1'b0}},
                                                 r_cfg.y_offset};
            rcfs_pkg::REG_BPP:         prdata = {{(PB-rcfs_pkg::BPP_BITS){1'b0}},
                                                 r_cfg.pix_depth};
            rcfs_pkg::REG_LINE_STRIDE: prdata = {{(PB-rcfs_pkg::STRIDE_BITS){1'b0}},
                                                 r_cfg.line_stride};
            default:                   prdata = '0;
        endcase
    end

    // Input register: refills in the same cycle that the scanner takes its item.
    assign o_in_ready = !r_in_vld || scan_ready;
    assign scan_take  = r_in_vld && scan_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_action <= i_action;
            r_in_pos_x  <= i_pos_x;
            r_in_pos_y  <= i_pos_y;
            r_in_width  <= i_rect_width;
            r_in_height <= i_rect_height;
            r_in_radius <= i_circle_radius;
            r_in_color  <= i_fill_color;
        end
    end

    rcfs_scan #(
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (r_in_vld),
        .o_in_ready      (scan_ready),
        .i_action        (r_in_action),
        .i_pos_x         (r_in_pos_x),
        .i_pos_y         (r_in_pos_y),
        .i_rect_width    (r_in_width),
        .i_rect_height   (r_in_height),
        .i_circle_radius (r_in_radius),
        .i_fill_color    (r_in_color),
        .o_pos_valid     (pos_valid),
        .i_pos_ready     (pos_ready),
        .o_pos_x         (pos_x),
        .o_pos_y         (pos_y),
        .o_dx            (pos_dx),
        .o_dy            (pos_dy),
        .o_radius        (pos_radius),
        .o_color         (pos_color),
        .o_ctl           (pos_ctl),
        .o_status        (scan_status)
    );

    rcfs_pix #(
        .COORD_BITS (COORD_BITS)
    ) u_pix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_pos_valid     (pos_valid),
        .o_pos_ready     (pos_ready),
        .i_pos_x         (pos_x),
        .i_pos_y         (pos_y),
        .i_dx            (pos_dx),
        .i_dy            (pos_dy),
        .i_radius        (pos_radius),
        .i_color         (pos_color),
        .i_ctl           (pos_ctl),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_write_enable  (o_write_enable),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_last_position (o_last_position)
    );

    // An item that is not a step on an active shape must not produce a scan position.
    `RCFS_ASSERT_NEXT(a_no_pos_without_step,
        scan_take && !(r_in_action == rcfs_pkg::ACT_STEP && scan_status.busy),
        !pos_valid, "scan position produced by an item that is not an active step")

    // A rectangle with no area leaves the scanner idle.
    `RCFS_ASSERT_NEXT(a_empty_rect_idle,
        scan_take && r_in_action == rcfs_pkg::ACT_RECT
            && (r_in_width == '0 || r_in_height == '0),
        !scan_status.busy, "empty rectangle left the scanner busy")

    // The final scan position ends the shape and is marked as last.
    `RCFS_ASSERT_NEXT(a_last_ends_shape,
        scan_take && r_in_action == rcfs_pkg::ACT_STEP && scan_status.busy
            && scan_status.at_last,
        !scan_status.busy && pos_valid && pos_ctl.last,
        "final scan position did not end the shape")

endmodule

// ===== verif/fill_scanner_checker.sv =====
// Fill scanner checker: tracks registers, checks reads, predicts every pixel write, compares.
`timescale 1ns / 100ps

module fill_scanner_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rcfs_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [rcfs_pkg::PDATA_BITS-1:0]  pwdata,
    input  logic [rcfs_pkg::PDATA_BITS-1:0]  prdata,
    input  logic                             pready,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [1:0]                       i_action,
    input  logic signed [rcfs_pkg::COORD_BITS_DEF-1:0] i_pos_x,
    input  logic signed [rcfs_pkg::COORD_BITS_DEF-1:0] i_pos_y,
    input  logic [rcfs_pkg::COORD_BITS_DEF-1:0] i_rect_width,
    input  logic [rcfs_pkg::COORD_BITS_DEF-1:0] i_rect_height,
    input  logic [rcfs_pkg::COORD_BITS_DEF-2:0] i_circle_radius,
    input  logic [rcfs_pkg::COLOR_BITS-1:0]  i_fill_color,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_write_enable,
    input  logic [rcfs_pkg::ADDR_BITS-1:0]   i_pixel_address,
    input  logic [rcfs_pkg::COLOR_BITS-1:0]  i_pixel_value,
    input  logic                             i_last_position,
    output int                               o_failures,
    output int                               o_pending,
    output int                               o_results,
    output int                               o_enabled
);

    localparam int CB        = rcfs_pkg::COORD_BITS_DEF;
    localparam int SCAN_BITS = CB + 2;
    localparam int AB        = rcfs_pkg::ADDR_BITS;
    localparam int DB        = rcfs_pkg::PDATA_BITS;

    typedef struct packed {
        logic                            write_enable;
        logic [AB-1:0]                   pixel_address;
        logic [rcfs_pkg::COLOR_BITS-1:0] pixel_value;
        logic                            last_position;
    } t_pixel_write;

    rcfs_pkg::t_cfg                  cfg;
    logic                            active;
    logic                            circle;
    logic signed [SCAN_BITS-1:0]     cur_x, cur_y, row_x, end_x, end_y;
    logic signed [CB-1:0]            ctr_x, ctr_y;
    logic [CB-2:0]                   rad;
    logic [rcfs_pkg::COLOR_BITS-1:0] color;

    t_pixel_write expected_writes[$];
    int mismatches = 0;
    int results    = 0;
    int enabled    = 0;
    int queued     = 0;

    assign o_failures = mismatches;
    assign o_pending  = queued;
    assign o_results  = results;
    assign o_enabled  = enabled;

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("[%0t] pixel check: %s is %h, expected %h", $realtime, what, got, want);
    endtask

    // Byte address of a scan position; all terms wrap at 32 bits.
    function automatic logic [AB-1:0] pixel_address(logic signed [SCAN_BITS-1:0] x,
                                                    logic signed [SCAN_BITS-1:0] y);
        logic [AB-1:0] ax;
        logic [AB-1:0] ay;
        logic [AB-1:0] col_bytes;
        ax        = AB'(int'(x) + int'(cfg.x_offset));
        ay        = AB'(int'(y) + int'(cfg.y_offset));
        col_bytes = AB'(cfg.pix_depth >> rcfs_pkg::BYTE_SHIFT);
        return cfg.frame_base + ax * col_bytes + ay * AB'(cfg.line_stride);
    endfunction

    always @(posedge i_clk) begin : model
        t_pixel_write       want;
        rcfs_pkg::t_reg_idx reg_sel;
        logic [DB-1:0]      reg_now;
        longint             dx;
        longint             dy;
        if (!i_rst_n) begin
            cfg           = '0;
            cfg.pix_depth = rcfs_pkg::BPP_RESET;
            active        = 1'b0;
            circle        = 1'b0;
            cur_x         = '0;
            cur_y         = '0;
            row_x         = '0;
            end_x         = '0;
            end_y         = '0;
            ctr_x         = '0;
            ctr_y         = '0;
            rad           = '0;
            color         = '0;
            expected_writes.delete();
        end else begin
            if (psel && penable && pready) begin
                reg_sel = rcfs_pkg::t_reg_idx'(paddr[rcfs_pkg::PADDR_BITS-1:2]);
                case (reg_sel)
                    rcfs_pkg::REG_FRAME_BASE: reg_now = DB'(cfg.frame_base);
                    rcfs_pkg::REG_X_OFFSET:   reg_now = DB'(cfg.x_offset);
                    rcfs_pkg::REG_Y_OFFSET:   reg_now = DB'(cfg.y_offset);
                    rcfs_pkg::REG_BPP:        reg_now = DB'(cfg.pix_depth);
                    default:                  reg_now = DB'(cfg.line_stride);
                endcase
                if (pwrite) begin
                    case (reg_sel)
                        rcfs_pkg::REG_FRAME_BASE:
                            cfg.frame_base = pwdata[AB-1:0];
                        rcfs_pkg::REG_X_OFFSET:
                            cfg.x_offset = pwdata[rcfs_pkg::OFFSET_BITS-1:0];
                        rcfs_pkg::REG_Y_OFFSET:
                            cfg.y_offset = pwdata[rcfs_pkg::OFFSET_BITS-1:0];
                        rcfs_pkg::REG_BPP:
                            cfg.pix_depth = pwdata[rcfs_pkg::BPP_BITS-1:0];
                        rcfs_pkg::REG_LINE_STRIDE:
                            cfg.line_stride = pwdata[rcfs_pkg::STRIDE_BITS-1:0];
                        default: ;
                    endcase
                end else if (prdata !== reg_now) begin
                    note_mismatch($sformatf("read of %s", reg_sel.name()), prdata, reg_now);
                end
            end

            // Results are compared before this edge's item is taken, since an item
            // can never produce its result in the cycle it is accepted.
            if (i_out_valid && i_out_ready) begin
                if (expected_writes.size() == 0) begin
                    note_mismatch("unexpected item, address", i_pixel_address, '0);
                end else begin
                    want = expected_writes.pop_front();
                    if (i_write_enable !== want.write_enable)
                        note_mismatch("write_enable", 32'(i_write_enable),
                                      32'(want.write_enable));
                    if (i_pixel_address !== want.pixel_address)
                        note_mismatch("pixel_address", i_pixel_address, want.pixel_address);
                    if (i_pixel_value !== want.pixel_value)
                        note_mismatch("pixel_value", i_pixel_value, want.pixel_value);
                    if (i_last_position !== want.last_position)
                        note_mismatch("last_position", 32'(i_last_position),
                                      32'(want.last_position));
                    results++;
                    if (want.write_enable) enabled++;
                end
            end

            if (i_in_valid && i_in_ready) begin
                case (i_action)
                    rcfs_pkg::ACT_RECT: begin
                        circle = 1'b0;
                        color  = i_fill_color;
                        if (i_rect_width == '0 || i_rect_height == '0) begin
                            active = 1'b0;
                        end else begin
                            row_x  = i_pos_x;
                            cur_x  = i_pos_x;
                            cur_y  = i_pos_y;
                            end_x  = SCAN_BITS'(int'(i_pos_x) + int'(i_rect_width) - 1);
                            end_y  = SCAN_BITS'(int'(i_pos_y) + int'(i_rect_height) - 1);
                            active = 1'b1;
                        end
                    end
                    rcfs_pkg::ACT_CIRCLE: begin
                        circle = 1'b1;
                        color  = i_fill_color;
                        ctr_x  = i_pos_x;
                        ctr_y  = i_pos_y;
                        rad    = i_circle_radius;
                        row_x  = SCAN_BITS'(int'(i_pos_x) - int'(i_circle_radius));
                        cur_x  = row_x;
                        cur_y  = SCAN_BITS'(int'(i_pos_y) - int'(i_circle_radius));
                        end_x  = SCAN_BITS'(int'(i_pos_x) + int'(i_circle_radius));
                        end_y  = SCAN_BITS'(int'(i_pos_y) + int'(i_circle_radius));
                        active = 1'b1;
                    end
                    rcfs_pkg::ACT_STEP: begin
                        if (active) begin
                            want.last_position = (cur_x == end_x) && (cur_y == end_y);
                            want.write_enable  = 1'b1;
                            if (circle) begin
                                dx = longint'(cur_x) - longint'(ctr_x);
                                dy = longint'(cur_y) - longint'(ctr_y);
                                want.write_enable = (dx * dx + dy * dy) <=
                                                    longint'(rad) * longint'(rad);
                            end
                            want.pixel_address = pixel_address(cur_x, cur_y);
                            want.pixel_value   = color;
                            expected_writes.push_back(want);
                            if (want.last_position) begin
                                active = 1'b0;
                            end else if (cur_x == end_x) begin
                                cur_x = row_x;
                                cur_y = cur_y + 1;
                            end else begin
                                cur_x = cur_x + 1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        queued = expected_writes.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the fill scanner: clock, reset, register setup, item stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int CB             = rcfs_pkg::COORD_BITS_DEF;
    localparam int CLB            = rcfs_pkg::COLOR_BITS;
    localparam int DB             = rcfs_pkg::PDATA_BITS;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 130;
    localparam int RANDOM_SETS    = 5;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_LONG} t_stall_mode;

    typedef struct {
        logic [1:0]           action;
        logic signed [CB-1:0] pos_x;
        logic signed [CB-1:0] pos_y;
        logic [CB-1:0]        rect_width;
        logic [CB-1:0]        rect_height;
        logic [CB-2:0]        circle_radius;
        logic [CLB-1:0]       fill_color;
    } t_fill_cmd;

    logic                                clk     = 1'b0;
    logic                                rst_n   = 1'b0;
    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [rcfs_pkg::PADDR_BITS-1:0]     paddr   = '0;
    logic [DB-1:0]                       pwdata  = '0;
    logic [DB-1:0]                       prdata;
    logic                                pready;
    logic                                in_valid      = 1'b0;
    logic                                in_ready;
    logic [1:0]                          action        = '0;
    logic signed [CB-1:0]                pos_x         = '0;
    logic signed [CB-1:0]                pos_y         = '0;
    logic [CB-1:0]                       rect_width    = '0;
    logic [CB-1:0]                       rect_height   = '0;
    logic [CB-2:0]                       circle_radius = '0;
    logic [CLB-1:0]                      fill_color    = '0;
    logic                                out_valid;
    logic                                out_ready     = 1'b0;
    logic                                write_enable;
    logic [rcfs_pkg::ADDR_BITS-1:0]      pixel_address;
    logic [CLB-1:0]                      pixel_value;
    logic                                last_position;

    int failures;
    int pending;
    int results;
    int enabled;

    int burst_left    = 0;
    int starts_sent   = 0;
    int steps_sent    = 0;
    int settings_used = 1;
    int idle_cycles   = 0;

    t_stall_mode rx_mode      = STALL_NONE;
    int          rx_mode_left = 0;
    int          rx_hold      = 0;
    int          rx_tick      = 0;

    always #2 clk = ~clk;

    rect_circle_fill_scanner_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (action),
        .i_pos_x         (pos_x),
        .i_pos_y         (pos_y),
        .i_rect_width    (rect_width),
        .i_rect_height   (rect_height),
        .i_circle_radius (circle_radius),
        .i_fill_color    (fill_color),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_write_enable  (write_enable),
        .o_pixel_address (pixel_address),
        .o_pixel_value   (pixel_value),
        .o_last_position (last_position)
    );

    fill_scanner_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_action        (action),
        .i_pos_x         (pos_x),
        .i_pos_y         (pos_y),
        .i_rect_width    (rect_width),
        .i_rect_height   (rect_height),
        .i_circle_radius (circle_radius),
        .i_fill_color    (fill_color),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_write_enable  (write_enable),
        .i_pixel_address (pixel_address),
        .i_pixel_value   (pixel_value),
        .i_last_position (last_position),
        .o_failures      (failures),
        .o_pending       (pending),
        .o_results       (results),
        .o_enabled       (enabled)
    );

    // The result side switches among four stall patterns, chosen at random.
    always @(negedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_stall_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(32, 256);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            STALL_NONE:     out_ready <= 1'b1;
            STALL_COIN:     out_ready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: out_ready <= (rx_tick % 4) != 0;
            default: begin
                if (rx_hold == 0 && $urandom_range(0, 9) == 0) rx_hold = $urandom_range(1, 16);
                if (rx_hold != 0) begin
                    rx_hold--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("rect_circle_fill_scanner_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_fill_cmd make_cmd(logic [1:0] act, int px, int py, int w, int h,
                                           int r, logic [CLB-1:0] color);
        t_fill_cmd c;
        c.action        = act;
        c.pos_x         = CB'(px);
        c.pos_y         = CB'(py);
        c.rect_width    = CB'(w);
        c.rect_height   = CB'(h);
        c.circle_radius = (CB-1)'(r);
        c.fill_color    = color;
        return c;
    endfunction

    function automatic t_fill_cmd rand_cmd();
        t_fill_cmd c;
        c.action        = 2'($urandom_range(0, 3));
        c.pos_x         = CB'($urandom);
        c.pos_y         = CB'($urandom);
        c.rect_width    = CB'($urandom);
        c.rect_height   = CB'($urandom);
        c.circle_radius = (CB-1)'($urandom);
        c.fill_color    = $urandom;
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_cmd(t_fill_cmd c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        in_valid      <= 1'b1;
        action        <= c.action;
        pos_x         <= c.pos_x;
        pos_y         <= c.pos_y;
        rect_width    <= c.rect_width;
        rect_height   <= c.rect_height;
        circle_radius <= c.circle_radius;
        fill_color    <= c.fill_color;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (c.action == rcfs_pkg::ACT_STEP) steps_sent++;
        else if (c.action != ACT_UNUSED) starts_sent++;
    endtask

    task automatic send_steps(int n);
        t_fill_cmd c;
        for (int k = 0; k < n; k++) begin
            c        = rand_cmd();
            c.action = rcfs_pkg::ACT_STEP;
            send_cmd(c);
        end
    endtask

    // Holds the item channel until every pixel has come out and the pipeline is empty.
    task automatic drain();
        in_valid  <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(bit wr, rcfs_pkg::t_reg_idx idx, logic [DB-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic read_all_regs();
        for (int k = 0; k <= int'(rcfs_pkg::REG_LINE_STRIDE); k++) begin
            apb_access(1'b0, rcfs_pkg::t_reg_idx'(k), '0);
        end
    endtask

    task automatic set_config(logic [31:0] base, int xo, int yo, int bpp, int stride);
        drain();
        apb_access(1'b1, rcfs_pkg::REG_FRAME_BASE, base);
        apb_access(1'b1, rcfs_pkg::REG_X_OFFSET, DB'(xo));
        apb_access(1'b1, rcfs_pkg::REG_Y_OFFSET, DB'(yo));
        apb_access(1'b1, rcfs_pkg::REG_BPP, DB'(bpp));
        apb_access(1'b1, rcfs_pkg::REG_LINE_STRIDE, DB'(stride));
        read_all_regs();
        settings_used++;
    endtask

    // Mostly complete shapes with random content, plus abandoned shapes and loose items.
    task automatic run_random(int quota);
        t_fill_cmd c;
        int        done_items;
        int        seq;
        int        kind;
        int        n;
        int        extra;
        done_items = 0;
        seq        = 0;
        while (done_items < quota) begin
            if (seq == 2 || $urandom_range(0, 14) == 0) begin
                in_valid  <= 1'b0;
                burst_left = 0;
                do @(negedge clk); while (pending != 0);
            end
            kind = $urandom_range(0, 99);
            c    = rand_cmd();
            if (kind < 65) begin
                if ($urandom_range(0, 1) == 1) begin
                    c.action      = rcfs_pkg::ACT_RECT;
                    c.rect_width  = CB'(($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                                    : $urandom_range(1, 6));
                    c.rect_height = CB'($urandom_range(1, 5));
                    n = int'(c.rect_width) * int'(c.rect_height);
                end else begin
                    c.action        = rcfs_pkg::ACT_CIRCLE;
                    c.circle_radius = (CB-1)'(($urandom_range(0, 11) == 0)
                                              ? $urandom_range(5, 7) : $urandom_range(0, 4));
                    n = (2 * int'(c.circle_radius) + 1) * (2 * int'(c.circle_radius) + 1);
                end
                send_cmd(c);
                send_steps(n);
                done_items += n + 1;
                // A few steps past the end of the shape land on an idle block.
                if ($urandom_range(0, 4) == 0) begin
                    extra = $urandom_range(1, 3);
                    send_steps(extra);
                    done_items += extra;
                end
            end else if (kind < 80) begin
                c.action = ($urandom_range(0, 1) == 1) ? rcfs_pkg::ACT_RECT
                                                       : rcfs_pkg::ACT_CIRCLE;
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 1) == 1) c.rect_width = '0;
                    else c.rect_height = '0;
                end
                n = $urandom_range(0, 12);
                send_cmd(c);
                send_steps(n);
                done_items += n + 1;
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) send_cmd(rand_cmd());
                done_items += n;
            end
            seq++;
        end
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        read_all_regs();

        // Directed items under the reset register values.
        send_steps(1);
        send_cmd(make_cmd(ACT_UNUSED, -1, -1, 4095, 4095, 2047, 32'hFFFF_FFFF));
        send_cmd(make_cmd(rcfs_pkg::ACT_RECT, 5, 5, 0, 7, 0, 32'h1234_5678));
        send_cmd(make_cmd(rcfs_pkg::ACT_RECT, 5, 5, 7, 0, 0, 32'h8765_4321));
        send_steps(1);
        send_cmd(make_cmd(rcfs_pkg::ACT_CIRCLE, -2048, 2047, 0, 0, 0, 32'hFFFF_FFFF));
        send_steps(2);
        send_cmd(make_cmd(rcfs_pkg::ACT_RECT, 2047, -2048, 2, 2, 0, 32'h0000_0000));
        send_steps(4);
        send_cmd(make_cmd(rcfs_pkg::ACT_RECT, -2048, -2048, 4095, 4095, 0, 32'hA5A5_5A5A));
        send_steps(2);
        send_cmd(make_cmd(rcfs_pkg::ACT_CIRCLE, 2047, -2048, 0, 0, 2047, 32'h5A5A_A5A5));
        send_steps(2);
        send_cmd(make_cmd(rcfs_pkg::ACT_RECT, 0, 0, 1, 1, 0, 32'h8000_0001));
        send_steps(1);

        for (int s = 0; s < RANDOM_SETS; s++) begin
            case (s)
                0: set_config(32'hFFFF_FFFF, 4095, 4095, 32, 65535);
                1: set_config(32'h0000_0000, 0, 0, 0, 0);
                2: set_config($urandom, $urandom_range(0, 4095), $urandom_range(0, 4095),
                              8 * $urandom_range(0, 4), $urandom_range(0, 65535));
                default: set_config($urandom, $urandom_range(0, 4095), $urandom_range(0, 4095),
                                    $urandom_range(0, 32), $urandom_range(0, 65535));
            endcase
            run_random(ITEMS_PER_SET);
        end

        drain();
        $display("Sent %0d shape starts and %0d steps under %0d register settings.",
                 starts_sent, steps_sent, settings_used);
        $display("Checked %0d pixel items, %0d of them with the write enabled.",
                 results, enabled);
        if (failures == 0 && pending == 0) begin
            $display("rect_circle_fill_scanner_core: match");
        end else begin
            $display("rect_circle_fill_scanner_core: mismatch");
        end
        $finish;
    end

endmodule
